// ----- sv/imadec_pkg.sv -----
// Shared types, constants and table functions for the IMA ADPCM track decoder.
package imadec_pkg;

   // Header layout: predictor low, predictor high, step index, pad
   localparam int HEADER_BYTES = 4;
   localparam int STEP_TABLE_ENTRIES = 89;

   localparam int HDR_COUNT_W = $clog2(HEADER_BYTES + 1);
   localparam int POS_W = $clog2(STEP_TABLE_ENTRIES);

   localparam logic [HDR_COUNT_W-1:0] HDR_DONE = HDR_COUNT_W'(HEADER_BYTES);
   localparam logic [HDR_COUNT_W-1:0] HDR_PRED_HIGH = HDR_COUNT_W'(1);
   localparam logic [HDR_COUNT_W-1:0] HDR_INDEX = HDR_COUNT_W'(2);
   localparam logic [POS_W-1:0] STEP_LAST = POS_W'(STEP_TABLE_ENTRIES - 1);

   localparam logic signed [15:0] FLOOR_RESET = 16'sh8000;
   localparam logic [14:0] CEILING_RESET = 15'h7FFF;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_FLOOR = 2'd0,
      CSR_CEILING = 2'd1
   } csr_index_type;

   // Decoder state that one nibble reads and updates
   typedef struct packed {
      logic signed [15:0] predictor;
      logic [POS_W-1:0] position;
   } sample_state_type;

   // Standard IMA step size table
   function automatic logic [14:0] step_size(input logic [POS_W-1:0] idx);
      logic [14:0] s;
      case (idx)
         7'd0: s = 15'd7;         7'd1: s = 15'd8;         7'd2: s = 15'd9;
         7'd3: s = 15'd10;        7'd4: s = 15'd11;        7'd5: s = 15'd12;
         7'd6: s = 15'd13;        7'd7: s = 15'd14;        7'd8: s = 15'd16;
         7'd9: s = 15'd17;        7'd10: s = 15'd19;       7'd11: s = 15'd21;
         7'd12: s = 15'd23;       7'd13: s = 15'd25;       7'd14: s = 15'd28;
         7'd15: s = 15'd31;       7'd16: s = 15'd34;       7'd17: s = 15'd37;
         7'd18: s = 15'd41;       7'd19: s = 15'd45;       7'd20: s = 15'd50;
         7'd21: s = 15'd55;       7'd22: s = 15'd60;       7'd23: s = 15'd66;
         7'd24: s = 15'd73;       7'd25: s = 15'd80;       7'd26: s = 15'd88;
         7'd27: s = 15'd97;       7'd28: s = 15'd107;      7'd29: s = 15'd118;
         7'd30: s = 15'd130;      7'd31: s = 15'd143;      7'd32: s = 15'd157;
         7'd33: s = 15'd173;      7'd34: s = 15'd190;      7'd35: s = 15'd209;
         7'd36: s = 15'd230;      7'd37: s = 15'd253;      7'd38: s = 15'd279;
         7'd39: s = 15'd307;      7'd40: s = 15'd337;      7'd41: s = 15'd371;
         7'd42: s = 15'd408;      7'd43: s = 15'd449;      7'd44: s = 15'd494;
         7'd45: s = 15'd544;      7'd46: s = 15'd598;      7'd47: s = 15'd658;
         7'd48: s = 15'd724;      7'd49: s = 15'd796;      7'd50: s = 15'd876;
         7'd51: s = 15'd963;      7'd52: s = 15'd1060;     7'd53: s = 15'd1166;
         7'd54: s = 15'd1282;     7'd55: s = 15'd1411;     7'd56: s = 15'd1552;
         7'd57: s = 15'd1707;     7'd58: s = 15'd1878;     7'd59: s = 15'd2066;
         7'd60: s = 15'd2272;     7'd61: s = 15'd2499;     7'd62: s = 15'd2749;
         7'd63: s = 15'd3024;     7'd64: s = 15'd3327;     7'd65: s = 15'd3660;
         7'd66: s = 15'd4026;     7'd67: s = 15'd4428;     7'd68: s = 15'd4871;
         7'd69: s = 15'd5358;     7'd70: s = 15'd5894;     7'd71: s = 15'd6484;
         7'd72: s = 15'd7132;     7'd73: s = 15'd7845;     7'd74: s = 15'd8630;
         7'd75: s = 15'd9493;     7'd76: s = 15'd10442;    7'd77: s = 15'd11487;
         7'd78: s = 15'd12635;    7'd79: s = 15'd13899;    7'd80: s = 15'd15289;
         7'd81: s = 15'd16818;    7'd82: s = 15'd18500;    7'd83: s = 15'd20350;
         7'd84: s = 15'd22385;    7'd85: s = 15'd24623;    7'd86: s = 15'd27086;
         7'd87: s = 15'd29794;    7'd88: s = 15'd32767;
         default: s = 15'd0;
      endcase
      return s;
   endfunction

   // Index adjustment by code magnitude (sign bit does not matter)
   function automatic logic signed [7:0] index_move(input logic [2:0] mag);
      logic signed [7:0] m;
      case (mag)
         3'd4: m = 8'sd2;
         3'd5: m = 8'sd4;
         3'd6: m = 8'sd6;
         3'd7: m = 8'sd8;
         default: m = -8'sd1;
      endcase
      return m;
   endfunction

   // Header index byte is signed; clamp into the table
   function automatic logic [POS_W-1:0] clamp_header_index(input logic [7:0] b);
      logic [POS_W-1:0] r;
      if (b[7]) begin
         r = '0;
      end else if (b > {1'b0, STEP_LAST}) begin
         r = STEP_LAST;
      end else begin
         r = b[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/imadec_channels.sv -----
// Valid/ready channel interfaces for track bytes and decoded samples.
interface imadec_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic track_start;

   modport source(output valid, data_byte, track_start, input ready);
   modport sink(input valid, data_byte, track_start, output ready);
endinterface

interface imadec_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] pcm_sample;
   logic byte_done;

   modport source(output valid, pcm_sample, byte_done, input ready);
   modport sink(input valid, pcm_sample, byte_done, output ready);
endinterface

// ----- sv/imadec_sample_unit.sv -----
// One IMA ADPCM nibble decode: difference, predictor clamp and index adapt.
module imadec_sample_unit import imadec_pkg::*; (
   input  sample_state_type   state_i,
   input  logic [3:0]         code,
   input  logic signed [15:0] floor_val,
   input  logic [14:0]        ceiling_val,
   output sample_state_type   state_o
);

   logic [14:0] step;
   logic [15:0] diff;
   logic signed [17:0] pred_ext;
   logic signed [17:0] floor_ext;
   logic signed [17:0] ceiling_ext;
   logic signed [17:0] sum;
   logic signed [17:0] raised;
   logic signed [17:0] limited;
   logic signed [7:0] pos_next;

   // Difference from the step size, shifted adds per code bit
   always_comb begin
      step = step_size(state_i.position);
      diff = {4'b0, step[14:3]};
      if (code[0]) begin
         diff = diff + {3'b0, step[14:2]};
      end
      if (code[1]) begin
         diff = diff + {2'b0, step[14:1]};
      end
      if (code[2]) begin
         diff = diff + {1'b0, step};
      end
   end

   // Predictor update, floor first then ceiling
   always_comb begin
      pred_ext = {{2{state_i.predictor[15]}}, state_i.predictor};
      floor_ext = {{2{floor_val[15]}}, floor_val};
      ceiling_ext = {3'b0, ceiling_val};
      if (code[3]) begin
         sum = pred_ext - $signed({2'b0, diff});
      end else begin
         sum = pred_ext + $signed({2'b0, diff});
      end
      raised = (sum < floor_ext) ? floor_ext : sum;
      limited = (raised > ceiling_ext) ? ceiling_ext : raised;
      state_o.predictor = limited[15:0];
   end

   // Step index adapt, clamped to the table
   always_comb begin
      pos_next = $signed({1'b0, state_i.position}) + index_move(code[2:0]);
      if (pos_next < 8'sd0) begin
         state_o.position = '0;
      end else if (pos_next > $signed({1'b0, STEP_LAST})) begin
         state_o.position = STEP_LAST;
      end else begin
         state_o.position = pos_next[POS_W-1:0];
      end
   end

endmodule

// ----- sv/ima_adpcm_track_decoder.sv -----
// Top level of the IMA ADPCM track decoder: byte register, sequencer, output register.
//
// Usage:
//   req_ch carries one track byte per beat; track_start marks the first of four
//   header bytes (predictor low, predictor high, signed step index, pad).
//   Every later byte yields two rsp_ch beats: the low-nibble sample with
//   byte_done 0, then the high-nibble sample with byte_done 1.
//   csr_* writes the predictor floor (index 0) and ceiling (index 1); write
//   only while the decoder is idle.
// Timing:
//   An accepted byte waits in the byte register; each of its samples goes
//   from the nibble decoder into the output register, low nibble first. A data
//   byte occupies the nibble decoder for both of its nibbles, so while rsp_ch
//   does not stall the sustained rate is one sample per cycle; header bytes give
//   no beat and do not wait on rsp_ch. The single nibble decoder, whose output
//   feeds the next nibble's state, sets that rate. A new byte is taken while
//   the second sample of the last one is being decoded.
// Reset: clears the channel state; predictor 0, step index 0, header complete,
//   floor -32768, ceiling 32767. When rsp_ch stalls, the output register holds
//   its beat and decoding pauses; the byte register then fills and req_ch stalls.
module ima_adpcm_track_decoder import imadec_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   imadec_req_if.sink          req_ch,
   imadec_rsp_if.source        rsp_ch,
   input  logic                csr_write_en,
   input  csr_index_type       csr_index,
   input  logic [15:0]         csr_wdata
);

   // Configuration registers
   logic signed [15:0] floor_ff;
   logic [14:0] ceiling_ff;

   // Byte register and nibble phase
   logic work_valid_ff;
   logic [7:0] work_byte_ff;
   logic work_start_ff;
   logic phase_ff;

   // Decoder state
   sample_state_type state_ff;
   sample_state_type state_in;
   sample_state_type unit_out;
   logic [HDR_COUNT_W-1:0] hdr_count_ff;
   logic [7:0] hdr_low_ff;

   // Output register
   logic rsp_valid_ff;
   logic signed [15:0] rsp_sample_ff;
   logic rsp_done_ff;

   logic req_beat;
   logic is_header;
   logic out_free;
   logic step_fire;
   logic work_done;
   logic sample_load;
   logic [3:0] nibble;

   // Handshake and sequencing
   assign req_beat = req_ch.valid && req_ch.ready;
   assign is_header = work_start_ff || (hdr_count_ff < HDR_DONE);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign step_fire = work_valid_ff && (is_header || out_free);
   assign work_done = step_fire && (is_header || phase_ff);
   assign sample_load = step_fire && !is_header;
   assign req_ch.ready = !work_valid_ff || work_done;
   assign nibble = phase_ff ? work_byte_ff[7:4] : work_byte_ff[3:0];

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pcm_sample = rsp_sample_ff;
   assign rsp_ch.byte_done = rsp_done_ff;

   imadec_sample_unit u_sample (
      .state_i    (state_ff),
      .code       (nibble),
      .floor_val  (floor_ff),
      .ceiling_val(ceiling_ff),
      .state_o    (unit_out)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_RESET;
         ceiling_ff <= CEILING_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FLOOR: floor_ff <= csr_wdata;
            CSR_CEILING: ceiling_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // Byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (req_beat) begin
         work_valid_ff <= 1'b1;
         phase_ff <= 1'b0;
      end else begin
         if (work_done) begin
            work_valid_ff <= 1'b0;
         end
         if (sample_load) begin
            phase_ff <= !phase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         work_byte_ff <= req_ch.data_byte;
         work_start_ff <= req_ch.track_start;
      end
   end

   // Next decoder state: header fields or nibble result
   always_comb begin
      state_in = state_ff;
      if (sample_load) begin
         state_in = unit_out;
      end else if (step_fire && !work_start_ff) begin
         if (hdr_count_ff == HDR_PRED_HIGH) begin
            state_in.predictor = {work_byte_ff, hdr_low_ff};
         end else if (hdr_count_ff == HDR_INDEX) begin
            state_in.position = clamp_header_index(work_byte_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         hdr_count_ff <= HDR_DONE;
         hdr_low_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (step_fire && is_header) begin
            if (work_start_ff) begin
               hdr_low_ff <= work_byte_ff;
               hdr_count_ff <= HDR_COUNT_W'(1);
            end else begin
               hdr_count_ff <= hdr_count_ff + HDR_COUNT_W'(1);
            end
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (sample_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_load) begin
         rsp_sample_ff <= unit_out.predictor;
         rsp_done_ff <= phase_ff;
      end
   end

   // Checks
   a_position_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff.position <= STEP_LAST)
      else $error("step index left the table");

   a_header_count_range: assert property (@(posedge clock) disable iff (reset)
      (hdr_count_ff != '0) && (hdr_count_ff <= HDR_DONE))
      else $error("header count out of range");

   a_phase_needs_byte: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (work_valid_ff && !is_header))
      else $error("high nibble pending without a data byte");

   a_high_follows_low: assert property (@(posedge clock) disable iff (reset)
      (sample_load && !phase_ff) |=> (work_valid_ff && phase_ff))
      else $error("low nibble not followed by high nibble");

endmodule
